/* hw/rtl/swsr_pkg.sv */
// shared types and constants for the single-wire sensor frame receiver
package swsr_pkg;

    localparam int FRAME_BITS   = 40;
    localparam int BITS_LEFT_W  = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int READING_W    = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW_TICKS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TIMEOUT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_LOW_TIMEOUT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RESPONSE_LOW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_THRESHOLD    = 3'd4;

    // reset values of the configuration registers
    localparam logic [15:0] START_LOW_TICKS_RST  = 16'd18000;
    localparam logic [7:0]  PHASE_TIMEOUT_RST    = 8'd90;
    localparam logic [7:0]  BIT_LOW_TIMEOUT_RST  = 8'd60;
    localparam logic [7:0]  MIN_RESPONSE_LOW_RST = 8'd60;
    localparam logic [7:0]  ONE_THRESHOLD_RST    = 8'd40;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_ACK       = 3'd3,
        PH_RESP_LOW  = 3'd4,
        PH_RESP_HIGH = 3'd5,
        PH_BIT_LOW   = 3'd6,
        PH_BIT_HIGH  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TIMEOUT   = 2'd1,
        ST_SHORT_ACK = 2'd2,
        ST_CHECKSUM  = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  phase_timeout;
        logic [7:0]  bit_low_timeout;
        logic [7:0]  min_response_low;
        logic [7:0]  one_threshold;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [READING_W-1:0] reading;
    } result_t;

endpackage

/* hw/rtl/swsr_frame_fsm.sv */
// exchange sequencer: phase timing, bit decode, checksum and stored reading
module swsr_frame_fsm
    import swsr_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    req_type,
    input  logic    line_level,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CMP_W = (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;

    phase_t                        phase_reg, phase_next;
    logic [TICK_COUNTER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [BITS_LEFT_W-1:0]        bits_left_reg, bits_left_next;
    logic [FRAME_BITS-1:0]         frame_reg, frame_next;
    logic [READING_W-1:0]          reading_reg, reading_next;
    logic [1:0]                    status_reg, status_next;
    logic                          done_next;

    always_comb
    begin
        logic [TICK_COUNTER_WIDTH-1:0] cnt;
        logic [CMP_W-1:0]              cnt_w;
        logic                          wait_level;
        logic                          timeout;
        logic                          bit_val;
        logic [7:0]                    sum;

        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        bits_left_next = bits_left_reg;
        frame_next     = frame_reg;
        reading_next   = reading_reg;
        status_next    = status_reg;
        done_next      = 1'b0;
        cnt            = elapsed_reg;
        cnt_w          = '0;
        wait_level     = 1'b0;
        timeout        = 1'b0;
        bit_val        = 1'b0;
        sum            = '0;

        if (step && !req_type && phase_reg == PH_START) begin
            if (elapsed_reg != '1)
                cnt = elapsed_reg + 1'b1;
            elapsed_next = cnt;
            if (CMP_W'(cnt) >= CMP_W'(cfg.start_low_ticks)) begin
                phase_next   = PH_RELEASE;
                elapsed_next = '0;
            end
        end else if (step && !req_type && phase_reg != PH_IDLE) begin
            wait_level = (phase_reg == PH_ACK) || (phase_reg == PH_RESP_HIGH)
                      || (phase_reg == PH_BIT_HIGH);
            if (line_level != wait_level) begin
                // level change ends this phase and opens the next one
                cnt = '0;
                case (phase_reg)
                    PH_RELEASE:   phase_next = PH_ACK;
                    PH_ACK:       phase_next = PH_RESP_LOW;
                    PH_RESP_LOW:
                    begin
                        if (CMP_W'(elapsed_reg) < CMP_W'(cfg.min_response_low)) begin
                            status_next = ST_SHORT_ACK;
                            done_next   = 1'b1;
                        end else begin
                            phase_next = PH_RESP_HIGH;
                        end
                    end
                    PH_RESP_HIGH:
                    begin
                        phase_next     = PH_BIT_LOW;
                        bits_left_next = BITS_LEFT_W'(FRAME_BITS);
                        frame_next     = '0;
                    end
                    PH_BIT_LOW:   phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        bit_val        = !(CMP_W'(elapsed_reg) < CMP_W'(cfg.one_threshold));
                        frame_next     = {frame_reg[FRAME_BITS-2:0], bit_val};
                        bits_left_next = bits_left_reg - 1'b1;
                        if (bits_left_next == '0) begin
                            sum = frame_next[39:32] + frame_next[31:24]
                                + frame_next[23:16] + frame_next[15:8];
                            if (sum == frame_next[7:0]) begin
                                reading_next = frame_next[39:8];
                                status_next  = ST_OK;
                            end else begin
                                status_next  = ST_CHECKSUM;
                            end
                            done_next = 1'b1;
                        end else begin
                            phase_next = PH_BIT_LOW;
                        end
                    end
                    default:      phase_next = phase_reg;
                endcase
            end
            if (done_next) begin
                phase_next   = PH_IDLE;
                elapsed_next = '0;
            end else begin
                if (cnt != '1)
                    cnt = cnt + 1'b1;
                cnt_w = CMP_W'(cnt);
                case (phase_next)
                    PH_RESP_LOW: timeout = cnt_w >= CMP_W'(cfg.phase_timeout);
                    PH_BIT_LOW:  timeout = cnt_w >  CMP_W'(cfg.bit_low_timeout);
                    default:     timeout = cnt_w >  CMP_W'(cfg.phase_timeout);
                endcase
                if (timeout) begin
                    status_next  = ST_TIMEOUT;
                    phase_next   = PH_IDLE;
                    elapsed_next = '0;
                    done_next    = 1'b1;
                end else begin
                    elapsed_next = cnt;
                end
            end
        end else if (step && req_type && phase_reg == PH_IDLE) begin
            phase_next   = PH_START;
            elapsed_next = '0;
        end
    end

    always_comb
    begin
        result.drive_low = (phase_next == PH_START);
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done_next;
        result.status    = status_next;
        result.reading   = reading_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            bits_left_reg <= '0;
            reading_reg   <= '0;
            status_reg    <= '0;
        end else begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            bits_left_reg <= bits_left_next;
            reading_reg   <= reading_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

/* hw/rtl/single_wire_sensor_frame_receiver.sv */
// top level of the single-wire sensor frame receiver: handshake, config and result registers
//
// host side of a single-wire humidity/temperature sensor exchange. each input word is either
// a one-microsecond tick carrying the sampled wire level (req_type 0) or a start request
// (req_type 1, taken only when idle). a start holds the wire low (drive_low) for
// start_low_ticks ticks, then the block times the sensor's acknowledge, response low/high
// and 40 data bits; a high pulse of one_threshold ticks or more is a one, msb first. the
// fifth byte must equal the low 8 bits of the sum of the first four. every input word gives
// exactly one result word: drive_low, busy_res, done_res (set on the word that ends an
// exchange), status of the last finished exchange and the four bytes of the last good frame.
// a word is registered on entry in the input register, evaluated against the sequencer state
// and lands in the output register; the sequencer update is one short combinational pass, so
// one word is taken every cycle while the output is not stalled. when a result waits in the
// output register the input register still takes one more word, then in_stall holds the
// upstream until the output register is taken. configuration is written through
// cfg_we/cfg_index/cfg_data, by the user only while idle; the block does not enforce it.
module single_wire_sensor_frame_receiver
    import swsr_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic                   line_level,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   drive_low,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [1:0]             status,
    output logic [7:0]             humidity_int,
    output logic [7:0]             humidity_frac,
    output logic [7:0]             temp_int,
    output logic [7:0]             temp_frac,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    logic    s1_valid_reg;
    logic    s1_req_reg;
    logic    s1_line_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;
    logic    in_take;

    // output register frees up when empty or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    // input register frees up when empty or moving forward
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.start_low_ticks  <= START_LOW_TICKS_RST;
            cfg_reg.phase_timeout    <= PHASE_TIMEOUT_RST;
            cfg_reg.bit_low_timeout  <= BIT_LOW_TIMEOUT_RST;
            cfg_reg.min_response_low <= MIN_RESPONSE_LOW_RST;
            cfg_reg.one_threshold    <= ONE_THRESHOLD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_LOW_TICKS:  cfg_reg.start_low_ticks  <= cfg_data;
                CFG_PHASE_TIMEOUT:    cfg_reg.phase_timeout    <= cfg_data[7:0];
                CFG_BIT_LOW_TIMEOUT:  cfg_reg.bit_low_timeout  <= cfg_data[7:0];
                CFG_MIN_RESPONSE_LOW: cfg_reg.min_response_low <= cfg_data[7:0];
                CFG_ONE_THRESHOLD:    cfg_reg.one_threshold    <= cfg_data[7:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            s1_req_reg  <= req_type;
            s1_line_reg <= line_level;
        end
    end

    // sequencer steps once per word moving into the output register
    swsr_frame_fsm #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_valid_reg && advance),
        .req_type   (s1_req_reg),
        .line_level (s1_line_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = out_reg.drive_low;
    assign busy_res      = out_reg.busy_res;
    assign done_res      = out_reg.done_res;
    assign status        = out_reg.status;
    assign humidity_int  = out_reg.reading[31:24];
    assign humidity_frac = out_reg.reading[23:16];
    assign temp_int      = out_reg.reading[15:8];
    assign temp_frac     = out_reg.reading[7:0];

endmodule

/* tb/tb.sv */
// self-checking testbench for the single-wire sensor frame receiver
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swsr_pkg::*;

    localparam int TICK_W       = 16;
    localparam int RANDOM_WORDS = 150;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = 1'b0;
    logic                   line_level = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   drive_low;
    logic                   busy_res;
    logic                   done_res;
    logic [1:0]             status;
    logic [7:0]             humidity_int;
    logic [7:0]             humidity_frac;
    logic [7:0]             temp_int;
    logic [7:0]             temp_frac;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_START_LOW_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    single_wire_sensor_frame_receiver #(
        .TICK_COUNTER_WIDTH(TICK_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .line_level   (line_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_low    (drive_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .humidity_int (humidity_int),
        .humidity_frac(humidity_frac),
        .temp_int     (temp_int),
        .temp_frac    (temp_frac),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // exchange predictor: own copy of the sequencer state and timing regs
    // ------------------------------------------------------------------
    cfg_t                   rx_cfg = '{start_low_ticks: START_LOW_TICKS_RST,
                                       phase_timeout: PHASE_TIMEOUT_RST,
                                       bit_low_timeout: BIT_LOW_TIMEOUT_RST,
                                       min_response_low: MIN_RESPONSE_LOW_RST,
                                       one_threshold: ONE_THRESHOLD_RST};
    phase_t                 rx_ph = PH_IDLE;
    logic [TICK_W-1:0]      rx_elapsed = '0;
    logic [BITS_LEFT_W-1:0] rx_bits_left = '0;
    logic [FRAME_BITS-1:0]  rx_frame = '0;
    logic [READING_W-1:0]   rx_reading = '0;
    status_t                rx_status = ST_OK;

    result_t pending_reports[$];   // report words predicted but not yet seen
    int      status_tally[4];      // ended exchanges per status code
    int      live_words;           // words that start or advance an exchange
    int      reports_seen;
    int      errors;
    int      cycles;
    int      idle_pct = 15;        // sender gap odds, percent per word
    int      stall_pct = 15;       // receiver stall odds, percent per cycle

    function automatic result_t sensor_exchange_step(input logic start_req, input logic level);
        result_t    rep;
        logic       ended;
        status_t    end_status;
        logic       wait_high;
        logic       too_long;
        logic [7:0] byte_sum;
        ended = 1'b0;
        end_status = ST_OK;
        too_long = 1'b0;
        if (rx_ph == PH_IDLE)
        begin
            // a tick while idle does nothing, a start opens the exchange
            if (start_req)
            begin
                rx_ph = PH_START;
                rx_elapsed = '0;
            end
        end
        else if (start_req)
        begin
            // start during an exchange is dropped, no time passes
        end
        else if (rx_ph == PH_START)
        begin
            if (rx_elapsed != '1)
                rx_elapsed++;
            if (rx_elapsed >= rx_cfg.start_low_ticks)
            begin
                rx_ph = PH_RELEASE;
                rx_elapsed = '0;
            end
        end
        else
        begin
            wait_high = (rx_ph == PH_ACK) || (rx_ph == PH_RESP_HIGH) || (rx_ph == PH_BIT_HIGH);
            // level change closes the phase and counts as the next phase's first tick
            if (level != wait_high)
            begin
                case (rx_ph)
                    PH_RELEASE: rx_ph = PH_ACK;
                    PH_ACK:     rx_ph = PH_RESP_LOW;
                    PH_RESP_LOW:
                    begin
                        if (rx_elapsed < rx_cfg.min_response_low)
                        begin
                            ended = 1'b1;
                            end_status = ST_SHORT_ACK;
                        end
                        else
                            rx_ph = PH_RESP_HIGH;
                    end
                    PH_RESP_HIGH:
                    begin
                        rx_ph = PH_BIT_LOW;
                        rx_bits_left = BITS_LEFT_W'(FRAME_BITS);
                        rx_frame = '0;
                    end
                    PH_BIT_LOW: rx_ph = PH_BIT_HIGH;
                    default:
                    begin
                        // end of a bit high pulse: decode by its length, msb first
                        rx_frame = {rx_frame[FRAME_BITS-2:0],
                                    rx_elapsed >= rx_cfg.one_threshold};
                        rx_bits_left--;
                        if (rx_bits_left == 0)
                        begin
                            // checksum is the wrapped 8-bit sum of the four data bytes
                            byte_sum = rx_frame[39:32] + rx_frame[31:24]
                                     + rx_frame[23:16] + rx_frame[15:8];
                            ended = 1'b1;
                            if (byte_sum == rx_frame[7:0])
                            begin
                                rx_reading = rx_frame[39:8];
                                end_status = ST_OK;
                            end
                            else
                                end_status = ST_CHECKSUM;
                        end
                        else
                            rx_ph = PH_BIT_LOW;
                    end
                endcase
                rx_elapsed = '0;
            end
            if (!ended)
            begin
                if (rx_elapsed != '1)
                    rx_elapsed++;
                case (rx_ph)
                    PH_RESP_LOW: too_long = rx_elapsed >= rx_cfg.phase_timeout;
                    PH_BIT_LOW:  too_long = rx_elapsed > rx_cfg.bit_low_timeout;
                    default:     too_long = rx_elapsed > rx_cfg.phase_timeout;
                endcase
                if (too_long)
                begin
                    ended = 1'b1;
                    end_status = ST_TIMEOUT;
                end
            end
        end
        // a failed exchange leaves the stored reading alone
        if (ended)
        begin
            rx_ph = PH_IDLE;
            rx_elapsed = '0;
            rx_status = end_status;
            status_tally[end_status]++;
        end
        rep.drive_low = (rx_ph == PH_START);
        rep.busy_res  = (rx_ph != PH_IDLE);
        rep.done_res  = ended;
        rep.status    = rx_status;
        rep.reading   = rx_reading;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // receiver side: random stalls, sampled old at each edge by the checker
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // one input word; valid stays up across back-to-back words
    task automatic send_word(input logic start_req, input logic level);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= start_req;
        line_level <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // idle ticks and starts while busy are dropped by the block
        if ((rx_ph == PH_IDLE) == start_req)
            live_words++;
        pending_reports.push_back(sensor_exchange_step(start_req, level));
    endtask

    // drop valid and let every predicted report come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // rewrite all five timing registers; 8-bit ones carry junk in the upper byte
    task automatic program_timing(input logic [15:0] start_ticks, input logic [7:0] resp_tmo,
                                  input logic [7:0] gap_tmo, input logic [7:0] min_resp,
                                  input logic [7:0] one_thr);
        logic [CFG_DATA_W-1:0] junk;
        settle();
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_START_LOW_TICKS, start_ticks);
        write_reg(CFG_PHASE_TIMEOUT, {junk[15:8], resp_tmo});
        write_reg(CFG_BIT_LOW_TIMEOUT, {junk[7:0], gap_tmo});
        write_reg(CFG_MIN_RESPONSE_LOW, {~junk[15:8], min_resp});
        write_reg(CFG_ONE_THRESHOLD, {~junk[7:0], one_thr});
        cfg_we <= 1'b0;
        rx_cfg.start_low_ticks  = start_ticks;
        rx_cfg.phase_timeout    = resp_tmo;
        rx_cfg.bit_low_timeout  = gap_tmo;
        rx_cfg.min_response_low = min_resp;
        rx_cfg.one_threshold    = one_thr;
    endtask

    // hold one level until the exchange ends, by timeout at the latest
    task automatic finish_exchange(input logic level);
        while (rx_ph != PH_IDLE)
            send_word(1'b0, level);
    endtask

    // mostly short pulses, sometimes exactly at either bound
    function automatic int pulse_len(input int lo, input int hi);
        int pick;
        pick = $urandom_range(7);
        if (hi <= lo)
            return lo;
        if (pick == 0)
            return hi;
        if (pick == 1)
            return lo;
        return $urandom_range((hi - lo > 5) ? lo + 5 : hi, lo);
    endfunction

    // full sensor exchange carrying frame_bits; fault_at names a pulse stretched one
    // tick past its limit (-1 for none), short_resp cuts the response low short
    task automatic play_frame(input logic [FRAME_BITS-1:0] frame_bits, input int fault_at,
                              input bit short_resp);
        int   tmo;
        int   gap;
        int   min_resp;
        int   thr;
        int   lo;
        int   hi;
        int   n;
        logic want_one;
        tmo      = int'(rx_cfg.phase_timeout);
        gap      = int'(rx_cfg.bit_low_timeout);
        min_resp = int'(rx_cfg.min_response_low);
        thr      = int'(rx_cfg.one_threshold);
        send_word(1'b1, 1'($urandom_range(1)));
        // start low period: the wire level is ignored, a stray start now and then
        while (rx_ph == PH_START)
            send_word($urandom_range(49) == 0, 1'($urandom_range(1)));
        // pulses alternate low/high: release, acknowledge, response low/high, then
        // 40 pairs of bit low and bit high
        for (int p = 0; p < 4 + 2 * FRAME_BITS && rx_ph != PH_IDLE; p++)
        begin
            if (p == 0)
            begin
                lo = 0;
                hi = tmo;
            end
            else if (p == 2)
            begin
                lo = (min_resp > 1) ? min_resp : 1;
                hi = tmo - 1;
                if (short_resp && min_resp > 1)
                begin
                    lo = 1;
                    hi = min_resp - 1;
                end
            end
            else if (p < 4)
            begin
                lo = 1;
                hi = tmo;
            end
            else if (p % 2 == 0)
            begin
                lo = 1;
                hi = gap;
            end
            else
            begin
                want_one = frame_bits[FRAME_BITS - 1 - (p - 5) / 2];
                lo = want_one ? ((thr > 1) ? thr : 1) : 1;
                hi = want_one ? tmo : thr - 1;
            end
            n = (p == fault_at) ? hi + 1 : pulse_len(lo, hi);
            for (int k = 0; k < n && rx_ph != PH_IDLE; k++)
                send_word(1'b0, 1'(p % 2));
        end
        // falling edge after the last bit ends the exchange
        if (rx_ph != PH_IDLE)
            send_word(1'b0, 1'b0);
        finish_exchange(1'($urandom_range(1)));
    endtask

    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [31:0] reading,
                                                          input bit good_sum);
        logic [7:0] chk;
        chk = reading[31:24] + reading[23:16] + reading[15:8] + reading[7:0];
        if (!good_sum)
            chk = chk ^ (8'($urandom_range(255, 1)));
        return {reading, chk};
    endfunction

    // ------------------------------------------------------------------
    // checker: compares each accepted report word with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("t=%0t report word with nothing expected", $time);
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_seen++;
                check_field("drive_low", int'(want.drive_low), int'(drive_low));
                check_field("busy_res", int'(want.busy_res), int'(busy_res));
                check_field("done_res", int'(want.done_res), int'(done_res));
                check_field("status", int'(want.status), int'(status));
                check_field("humidity_int", int'(want.reading[31:24]), int'(humidity_int));
                check_field("humidity_frac", int'(want.reading[23:16]), int'(humidity_frac));
                check_field("temp_int", int'(want.reading[15:8]), int'(temp_int));
                check_field("temp_frac", int'(want.reading[7:0]), int'(temp_frac));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("watchdog: no finish after %0d cycles, %0d reports outstanding",
                     cycles, pending_reports.size());
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timing values apart from a short start hold, no idling on either side:
    // ticks while idle, a start, starts while busy, then a held-high wire runs into
    // the acknowledge timeout
    task automatic test_reset_values();
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_START_LOW_TICKS, 16'd5);
        cfg_we <= 1'b0;
        rx_cfg.start_low_ticks = 16'd5;
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b1);
        finish_exchange(1'b1);
        idle_pct  = 15;
        stall_pct = 15;
    endtask

    // zero limits: zero start time releases after one tick, zero timeouts fail at once
    task automatic test_zero_limits();
        program_timing(16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(1'b1, 1'b0);
        finish_exchange(1'b0);
        send_word(1'b1, 1'b1);
        finish_exchange(1'b1);
        // response passes, zero bit-low limit trips on the first data bit
        program_timing(16'd0, 8'd255, 8'd0, 8'd0, 8'd0);
        play_frame(build_frame($urandom, 1'b1), -1, 1'b0);
    endtask

    // small timing: all-zero frame, wrapping checksum, bad checksum keeps the
    // old reading, short response, timeout in a bit high pulse
    task automatic test_checksum_cases();
        program_timing(16'd2, 8'd6, 8'd3, 8'd2, 8'd3);
        play_frame({FRAME_BITS{1'b0}}, -1, 1'b0);
        play_frame({32'hFFFF_FFFF, 8'hFC}, -1, 1'b0);
        play_frame({32'h0102_0304, 8'h0B}, -1, 1'b0);
        play_frame(build_frame($urandom, 1'b1), -1, 1'b1);
        play_frame(build_frame($urandom, 1'b1), 41, 1'b0);
    endtask

    // widest limits: every limit at 255 after a long start hold, the short
    // response ends the exchange before the data bits
    task automatic test_extreme_limits();
        program_timing(16'd100, 8'd255, 8'd255, 8'd255, 8'd255);
        play_frame(build_frame($urandom, 1'b1), -1, 1'b1);
    endtask

    // mostly well-formed frames with random content and timing, plus stretched
    // pulses, short responses, bad checksums and line noise
    task automatic test_random_exchanges();
        int              goal;
        int              frames;
        int              kind;
        int              tmo;
        int              thr;
        logic [FRAME_BITS-1:0] frame_bits;
        goal = live_words + RANDOM_WORDS;
        frames = 0;
        while (live_words < goal)
        begin
            if (frames % 3 == 0)
            begin
                tmo = ($urandom_range(5) == 0) ? $urandom_range(20, 2) : $urandom_range(6, 2);
                thr = $urandom_range(tmo, 2);
                program_timing(16'($urandom_range(4)), 8'(tmo), 8'($urandom_range(4, 1)),
                               8'($urandom_range(tmo - 1, 1)), 8'(thr));
            end
            frames++;
            frame_bits = build_frame($urandom, $urandom_range(4) != 0);
            kind = $urandom_range(9);
            if (kind <= 6)
                play_frame(frame_bits, -1, 1'b0);
            else if (kind == 7)
                play_frame(frame_bits, $urandom_range(3 + 2 * FRAME_BITS), 1'b0);
            else if (kind == 8)
                play_frame(frame_bits, -1, 1'b1);
            else
            begin
                // noise on the wire after a start
                send_word(1'b1, 1'($urandom_range(1)));
                repeat ($urandom_range(40, 5))
                    send_word($urandom_range(9) == 0, 1'($urandom_range(1)));
                finish_exchange(1'($urandom_range(1)));
            end
            repeat ($urandom_range(3))
                send_word(1'b0, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_zero_limits();
        test_checksum_cases();
        test_extreme_limits();
        test_random_exchanges();
        settle();
        $display("covered: %0d report words checked, %0d words drove an exchange",
                 reports_seen, live_words);
        $display("covered: exchanges ended ok %0d, timeout %0d, short response %0d, checksum %0d",
                 status_tally[ST_OK], status_tally[ST_TIMEOUT], status_tally[ST_SHORT_ACK],
                 status_tally[ST_CHECKSUM]);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
